### hdl/integer_literal_parser_unit_defines.svh
// Assertion macros for the integer literal parser.
// No dependencies; included by the top level only.
`ifndef INTEGER_LITERAL_PARSER_UNIT_DEFINES_SVH
`define INTEGER_LITERAL_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define ILP_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("integer literal parser check failed");
`define ILP_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("integer literal parser invariant failed");
`else
`define ILP_ASSERT(label, prop)
`define ILP_ASSERT_ALWAYS(label, prop)
`endif

`endif

### hdl/ilp_pkg.sv
// Types, character constants and keyword tables for the integer literal parser.
// No dependencies.
package ilp_pkg;

    typedef enum logic [2:0] {
        PH_START,
        PH_SIGN,
        PH_ZERO,
        PH_PREFIX,
        PH_DIGITS,
        PH_WORD
    } t_phase;

    typedef enum logic [1:0] {
        RADIX_DEC,
        RADIX_BIN,
        RADIX_OCT,
        RADIX_HEX
    } t_radix;

    localparam logic [7:0] CASE_MASK     = 8'hDF;
    localparam logic [7:0] LOWER_BIT     = 8'h20;
    localparam logic [7:0] CH_MINUS      = "-";
    localparam logic [7:0] CH_PLUS       = "+";
    localparam logic [7:0] CH_ZERO       = "0";
    localparam logic [7:0] CH_NINE       = "9";
    localparam logic [7:0] CH_UNDERSCORE = "_";
    localparam logic [7:0] CH_UPPER_A    = "A";
    localparam logic [7:0] CH_UPPER_Z    = "Z";
    localparam logic [7:0] CH_LOWER_B    = "b";
    localparam logic [7:0] CH_LOWER_O    = "o";
    localparam logic [7:0] CH_LOWER_X    = "x";
    // upper-case letter minus this offset gives its digit value 10..35
    localparam logic [7:0] LETTER_OFFSET = 8'h37;
    localparam logic [5:0] DIGIT_NONE    = 6'd63;

    localparam int         KW_COUNT      = 3;
    localparam logic [1:0] KW_FALSE      = 2'd0;
    localparam logic [1:0] KW_NULL       = 2'd1;
    localparam logic [1:0] KW_TRUE       = 2'd2;
    localparam logic [2:0] KW_POS_MAX    = 3'd7;

    function automatic logic [4:0] f_radix(input t_radix code);
        logic [4:0] r;
        case (code)
            RADIX_DEC: r = 5'd10;
            RADIX_BIN: r = 5'd2;
            RADIX_OCT: r = 5'd8;
            RADIX_HEX: r = 5'd16;
            default:   r = 5'd10;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] f_digit(input logic [7:0] b);
        logic [7:0] up;
        logic [5:0] d;
        up = b & CASE_MASK;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            d = {2'b00, b[3:0]};
        end else if (up >= CH_UPPER_A && up <= CH_UPPER_Z) begin
            d = 6'(up - LETTER_OFFSET);
        end else begin
            d = DIGIT_NONE;
        end
        return d;
    endfunction

    function automatic logic [2:0] f_kw_len(input logic [1:0] k);
        logic [2:0] n;
        case (k)
            KW_FALSE: n = 3'd5;
            KW_NULL:  n = 3'd4;
            KW_TRUE:  n = 3'd4;
            default:  n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] f_kw_char(input logic [1:0] k, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        case (k)
            KW_FALSE: begin
                case (pos)
                    3'd0:    c = "f";
                    3'd1:    c = "a";
                    3'd2:    c = "l";
                    3'd3:    c = "s";
                    3'd4:    c = "e";
                    default: c = 8'h00;
                endcase
            end
            KW_NULL: begin
                case (pos)
                    3'd0:    c = "n";
                    3'd1:    c = "u";
                    3'd2:    c = "l";
                    3'd3:    c = "l";
                    default: c = 8'h00;
                endcase
            end
            KW_TRUE: begin
                case (pos)
                    3'd0:    c = "t";
                    3'd1:    c = "r";
                    3'd2:    c = "u";
                    3'd3:    c = "e";
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic f_kw_hit(input logic [1:0] k, input logic [2:0] pos,
                                      input logic [7:0] b);
        return (pos < f_kw_len(k)) && (f_kw_char(k, pos) == b);
    endfunction

endpackage

### hdl/integer_literal_parser_unit.sv
// Integer literal parser: one token byte per word, signed 64-bit result at the last word.
// The result is registered when the word marked last is accepted.
// Throughput: one word per cycle; a result held by a low i_ready stalls the input.
// Reset (synchronous, active low) clears the token state and sets detect_base to 1.
// Depends on ilp_pkg and integer_literal_parser_unit_defines.svh.
`include "integer_literal_parser_unit_defines.svh"

module integer_literal_parser_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_char_code,
    input  logic                i_has_char,
    input  logic                i_last,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [63:0]  o_value,
    output logic                o_valid_res,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);

    ilp_pkg::t_phase r_phase, n_phase;
    ilp_pkg::t_radix r_radix, n_radix;
    logic        r_negative, n_negative;
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_nacc, n_nacc;    // always equals -r_acc
    logic        r_failed, n_failed;
    logic [2:0]  r_cand, n_cand;
    logic [2:0]  r_pos, n_pos;
    logic        r_detect_base;

    logic        r_out_valid;
    logic [63:0] r_value;
    logic        r_valid_res;

    logic        accept;
    logic        take_digit;
    logic        origin;
    logic [5:0]  digit;
    logic [63:0] dig_ext;
    logic [7:0]  low_char;
    logic [2:0]  w_cand_in, w_cand_out;
    logic [2:0]  w_pos_in, w_pos_out;
    logic [63:0] fin_value;
    logic        fin_ok;

    assign o_ready     = !r_out_valid || i_ready;
    assign accept      = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_value     = r_value;
    assign o_valid_res = r_valid_res;

    assign digit    = ilp_pkg::f_digit(i_char_code);
    assign dig_ext  = {58'd0, digit};
    assign low_char = i_char_code | ilp_pkg::LOWER_BIT;

    // keyword step; the first word of a keyword starts from all candidates
    always_comb begin
        w_cand_in = (r_phase == ilp_pkg::PH_WORD) ? r_cand : 3'b111;
        w_pos_in  = (r_phase == ilp_pkg::PH_WORD) ? r_pos : 3'd0;
        w_cand_out = w_cand_in;
        for (int k = 0; k < ilp_pkg::KW_COUNT; k++) begin
            if (w_cand_in[k] && !ilp_pkg::f_kw_hit(2'(k), w_pos_in, i_char_code)) begin
                w_cand_out[k] = 1'b0;
            end
        end
        w_pos_out = (w_pos_in == ilp_pkg::KW_POS_MAX) ? w_pos_in : w_pos_in + 3'd1;
    end

    always_comb begin
        n_phase    = r_phase;
        n_radix    = r_radix;
        n_negative = r_negative;
        n_acc      = r_acc;
        n_nacc     = r_nacc;
        n_failed   = r_failed;
        n_cand     = r_cand;
        n_pos      = r_pos;
        take_digit = 1'b0;
        origin     = 1'b0;

        if (i_has_char && !r_failed) begin
            case (r_phase)
                ilp_pkg::PH_START: begin
                    if (i_char_code == ilp_pkg::CH_MINUS) begin
                        n_negative = 1'b1;
                        n_phase    = ilp_pkg::PH_SIGN;
                    end else if (i_char_code == ilp_pkg::CH_PLUS) begin
                        n_phase = ilp_pkg::PH_SIGN;
                    end else if (i_char_code == ilp_pkg::CH_ZERO && r_detect_base) begin
                        n_phase = ilp_pkg::PH_ZERO;
                    end else begin
                        take_digit = 1'b1;
                        origin     = 1'b1;
                    end
                end
                ilp_pkg::PH_SIGN: begin
                    if (i_char_code == ilp_pkg::CH_ZERO && r_detect_base) begin
                        n_phase = ilp_pkg::PH_ZERO;
                    end else begin
                        take_digit = 1'b1;
                    end
                end
                ilp_pkg::PH_ZERO: begin
                    if (low_char == ilp_pkg::CH_LOWER_B) begin
                        n_radix = ilp_pkg::RADIX_BIN;
                        n_phase = ilp_pkg::PH_PREFIX;
                    end else if (low_char == ilp_pkg::CH_LOWER_O) begin
                        n_radix = ilp_pkg::RADIX_OCT;
                        n_phase = ilp_pkg::PH_PREFIX;
                    end else if (low_char == ilp_pkg::CH_LOWER_X) begin
                        n_radix = ilp_pkg::RADIX_HEX;
                        n_phase = ilp_pkg::PH_PREFIX;
                    end else if (i_char_code < ilp_pkg::CH_ZERO ||
                                 i_char_code > ilp_pkg::CH_NINE) begin
                        n_failed = 1'b1;
                    end else begin
                        take_digit = 1'b1;
                    end
                end
                ilp_pkg::PH_PREFIX, ilp_pkg::PH_DIGITS: begin
                    take_digit = 1'b1;
                end
                ilp_pkg::PH_WORD: begin
                    n_cand = w_cand_out;
                    n_pos  = w_pos_out;
                end
                default: begin
                    n_failed = 1'b1;
                end
            endcase

            if (take_digit) begin
                if (digit < {1'b0, ilp_pkg::f_radix(r_radix)}) begin
                    case (r_radix)
                        ilp_pkg::RADIX_DEC: begin
                            n_acc  = (r_acc << 3) + (r_acc << 1) + dig_ext;
                            n_nacc = (r_nacc << 3) + (r_nacc << 1) - dig_ext;
                        end
                        ilp_pkg::RADIX_BIN: begin
                            n_acc  = (r_acc << 1) + dig_ext;
                            n_nacc = (r_nacc << 1) - dig_ext;
                        end
                        ilp_pkg::RADIX_OCT: begin
                            n_acc  = (r_acc << 3) + dig_ext;
                            n_nacc = (r_nacc << 3) - dig_ext;
                        end
                        default: begin
                            n_acc  = (r_acc << 4) + dig_ext;
                            n_nacc = (r_nacc << 4) - dig_ext;
                        end
                    endcase
                    n_phase = ilp_pkg::PH_DIGITS;
                end else if (r_detect_base && i_char_code == ilp_pkg::CH_UNDERSCORE) begin
                    n_phase = ilp_pkg::PH_DIGITS;
                end else if (origin) begin
                    n_phase = ilp_pkg::PH_WORD;
                    n_cand  = w_cand_out;
                    n_pos   = w_pos_out;
                end else begin
                    n_failed = 1'b1;
                end
            end
        end
    end

    // end-of-token result from the updated state
    always_comb begin
        fin_value = 64'd0;
        fin_ok    = 1'b0;
        if (!n_failed) begin
            case (n_phase)
                ilp_pkg::PH_ZERO: begin
                    fin_ok = 1'b1;
                end
                ilp_pkg::PH_DIGITS: begin
                    fin_value = n_negative ? n_nacc : n_acc;
                    fin_ok    = 1'b1;
                end
                ilp_pkg::PH_WORD: begin
                    for (int k = 0; k < ilp_pkg::KW_COUNT; k++) begin
                        if (n_cand[k] && ilp_pkg::f_kw_len(2'(k)) == n_pos) begin
                            fin_value = (2'(k) == ilp_pkg::KW_TRUE) ? 64'd1 : 64'd0;
                            fin_ok    = 1'b1;
                        end
                    end
                end
                default: begin
                    fin_ok = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= ilp_pkg::PH_START;
            r_radix    <= ilp_pkg::RADIX_DEC;
            r_negative <= 1'b0;
            r_acc      <= 64'd0;
            r_nacc     <= 64'd0;
            r_failed   <= 1'b0;
            r_cand     <= 3'd0;
            r_pos      <= 3'd0;
        end else if (accept && i_last) begin
            r_phase    <= ilp_pkg::PH_START;
            r_radix    <= ilp_pkg::RADIX_DEC;
            r_negative <= 1'b0;
            r_acc      <= 64'd0;
            r_nacc     <= 64'd0;
            r_failed   <= 1'b0;
            r_cand     <= 3'd0;
            r_pos      <= 3'd0;
        end else if (accept) begin
            r_phase    <= n_phase;
            r_radix    <= n_radix;
            r_negative <= n_negative;
            r_acc      <= n_acc;
            r_nacc     <= n_nacc;
            r_failed   <= n_failed;
            r_cand     <= n_cand;
            r_pos      <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_detect_base <= 1'b1;
        end else if (i_cfg_valid) begin
            r_detect_base <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && i_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_last) begin
            r_value     <= fin_value;
            r_valid_res <= fin_ok;
        end
    end

    `ILP_ASSERT(a_last_gives_result, (accept && i_last) |=> o_valid)
    `ILP_ASSERT(a_invalid_is_zero, (o_valid && !o_valid_res) |-> (o_value == 64'sd0))
    `ILP_ASSERT(a_clear_after_last, (accept && i_last) |=>
        (r_phase == ilp_pkg::PH_START && !r_failed && r_acc == 64'd0))
    `ILP_ASSERT_ALWAYS(a_negated_copy, !i_rst_n || ((r_acc + r_nacc) == 64'd0))

endmodule

### sim/tb_integer_literal_parser_unit.sv
// Testbench for integer_literal_parser_unit: tokens of signed, prefixed, keyword and malformed
// text go in one byte per word; a scoreboard predicts each value and valid flag and checks them.
// Depends on ilp_pkg and the integer_literal_parser_unit RTL.
module tb_integer_literal_parser_unit;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int PHASE_WORDS    = 375;

    typedef logic [7:0] t_byte_q[$];

    typedef struct {
        logic [63:0] value;
        logic        ok;
    } t_literal_result;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_STALLS} t_rx_mode;

    class literal_tracker;
        logic            detect_base;
        ilp_pkg::t_phase phase;
        logic            negative;
        ilp_pkg::t_radix radix;
        logic [63:0]     acc;
        logic            failed;
        logic [2:0]      cand;
        logic [2:0]      kpos;
        string           kw_text[3];
        t_literal_result expected_q[$];
        int              errors;

        function new();
            detect_base                = 1'b1;
            errors                     = 0;
            kw_text[ilp_pkg::KW_FALSE] = "false";
            kw_text[ilp_pkg::KW_NULL]  = "null";
            kw_text[ilp_pkg::KW_TRUE]  = "true";
            clear_token();
        endfunction

        function void clear_token();
            phase    = ilp_pkg::PH_START;
            negative = 1'b0;
            radix    = ilp_pkg::RADIX_DEC;
            acc      = '0;
            failed   = 1'b0;
            cand     = '0;
            kpos     = '0;
        endfunction

        function int base_of();
            case (radix)
                ilp_pkg::RADIX_BIN: return 2;
                ilp_pkg::RADIX_OCT: return 8;
                ilp_pkg::RADIX_HEX: return 16;
                default:            return 10;
            endcase
        endfunction

        function int digit_of(logic [7:0] b);
            logic [7:0] up;
            up = b & ilp_pkg::CASE_MASK;
            if (b >= ilp_pkg::CH_ZERO && b <= ilp_pkg::CH_NINE) return int'(b - ilp_pkg::CH_ZERO);
            if (up >= ilp_pkg::CH_UPPER_A && up <= ilp_pkg::CH_UPPER_Z) begin
                return int'(up - ilp_pkg::CH_UPPER_A) + 10;
            end
            return int'(ilp_pkg::DIGIT_NONE);
        endfunction

        function void keyword_char(logic [7:0] b);
            for (int k = 0; k < ilp_pkg::KW_COUNT; k++) begin
                if (cand[k] && (kpos >= kw_text[k].len() || kw_text[k][kpos] != b)) begin
                    cand[k] = 1'b0;
                end
            end
            if (kpos < ilp_pkg::KW_POS_MAX) kpos = kpos + 3'd1;
        endfunction

        function void digit_char(logic [7:0] b, bit at_origin);
            int base;
            int d;
            base = base_of();
            d    = digit_of(b);
            if (d < base) begin
                acc   = acc * 64'(base) + 64'(d);
                phase = ilp_pkg::PH_DIGITS;
            end else if (detect_base && b == ilp_pkg::CH_UNDERSCORE) begin
                phase = ilp_pkg::PH_DIGITS;
            end else if (at_origin) begin
                phase = ilp_pkg::PH_WORD;
                cand  = 3'b111;
                kpos  = '0;
                keyword_char(b);
            end else begin
                failed = 1'b1;
            end
        endfunction

        function void after_sign(logic [7:0] b, bit at_origin);
            if (b == ilp_pkg::CH_ZERO && detect_base) phase = ilp_pkg::PH_ZERO;
            else digit_char(b, at_origin);
        endfunction

        function void take_char(logic [7:0] b);
            logic [7:0] low;
            if (failed) return;
            case (phase)
                ilp_pkg::PH_START: begin
                    if (b == ilp_pkg::CH_MINUS) begin
                        negative = 1'b1;
                        phase    = ilp_pkg::PH_SIGN;
                    end else if (b == ilp_pkg::CH_PLUS) begin
                        phase = ilp_pkg::PH_SIGN;
                    end else begin
                        after_sign(b, 1'b1);
                    end
                end
                ilp_pkg::PH_SIGN: after_sign(b, 1'b0);
                ilp_pkg::PH_ZERO: begin
                    low = b | ilp_pkg::LOWER_BIT;
                    if (low == ilp_pkg::CH_LOWER_B) begin
                        radix = ilp_pkg::RADIX_BIN;
                        phase = ilp_pkg::PH_PREFIX;
                    end else if (low == ilp_pkg::CH_LOWER_O) begin
                        radix = ilp_pkg::RADIX_OCT;
                        phase = ilp_pkg::PH_PREFIX;
                    end else if (low == ilp_pkg::CH_LOWER_X) begin
                        radix = ilp_pkg::RADIX_HEX;
                        phase = ilp_pkg::PH_PREFIX;
                    end else if (b < ilp_pkg::CH_ZERO || b > ilp_pkg::CH_NINE) begin
                        failed = 1'b1;
                    end else begin
                        digit_char(b, 1'b0);
                    end
                end
                ilp_pkg::PH_PREFIX, ilp_pkg::PH_DIGITS: digit_char(b, 1'b0);
                ilp_pkg::PH_WORD: keyword_char(b);
                default: failed = 1'b1;
            endcase
        endfunction

        function void take_word(logic [7:0] ch, logic has, logic lst);
            t_literal_result r;
            if (has) take_char(ch);
            if (lst) begin
                r.value = '0;
                r.ok    = 1'b0;
                if (!failed) begin
                    case (phase)
                        ilp_pkg::PH_ZERO: r.ok = 1'b1;
                        ilp_pkg::PH_DIGITS: begin
                            r.value = negative ? -acc : acc;
                            r.ok    = 1'b1;
                        end
                        ilp_pkg::PH_WORD: begin
                            for (int k = 0; k < ilp_pkg::KW_COUNT; k++) begin
                                if (cand[k] && kw_text[k].len() == int'(kpos)) begin
                                    r.value = (k == ilp_pkg::KW_TRUE) ? 64'd1 : 64'd0;
                                    r.ok    = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                expected_q.push_back(r);
                clear_token();
            end
        endfunction

        function void check_result(logic [63:0] value, logic ok);
            t_literal_result r;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result value %h valid %b", $time, value, ok);
                errors++;
                return;
            end
            r = expected_q.pop_front();
            if (value !== r.value) begin
                $display("%0t: value mismatch expected %h actual %h", $time, r.value, value);
                errors++;
            end
            if (ok !== r.ok) begin
                $display("%0t: valid_res mismatch expected %b actual %b", $time, r.ok, ok);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_char_code = '0;
    logic        i_has_char  = 1'b0;
    logic        i_last      = 1'b0;
    logic        i_ready     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        i_cfg_data  = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic signed [63:0] o_value;
    logic        o_valid_res;
    logic        o_cfg_ready;

    literal_tracker tracker = new();
    int          idle_cycles = 0;
    int          burst_left  = 0;
    int          word_count  = 0;
    t_rx_mode    rx_mode     = RX_OPEN;
    int          rx_count    = 0;
    int          stall_left  = 0;
    t_byte_q     raw;

    integer_literal_parser_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_char_code (i_char_code),
        .i_has_char  (i_has_char),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_value     (o_value),
        .o_valid_res (o_valid_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // result sink: picks a random stall pattern and changes it when its countdown runs out
    always @(posedge i_clk) begin
        if (rx_count == 0) begin
            rx_mode  <= t_rx_mode'($urandom_range(0, 3));
            rx_count <= $urandom_range(50, 300);
        end else begin
            rx_count <= rx_count - 1;
        end
        if (stall_left != 0) begin
            i_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            case (rx_mode)
                RX_OPEN:   i_ready <= 1'b1;
                RX_COIN:   i_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: i_ready <= (rx_count % 4 == 0);
                default: begin
                    i_ready <= 1'b1;
                    if ($urandom_range(0, 15) == 0) stall_left <= $urandom_range(5, 60);
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) tracker.check_result(o_value, o_valid_res);
            if (i_valid && o_ready) tracker.take_word(i_char_code, i_has_char, i_last);
            if (i_cfg_valid && o_cfg_ready) tracker.detect_base = i_cfg_data;
            if ((o_valid && i_ready) || (i_valid && o_ready) || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("integer_literal_parser_unit test failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic send_word(input logic [7:0] ch, input logic has, input logic lst);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        i_valid     <= 1'b1;
        i_char_code <= ch;
        i_has_char  <= has;
        i_last      <= lst;
        do @(posedge i_clk); while (!o_ready);
        burst_left--;
        if (has || lst) word_count++;
    endtask

    task automatic send_token(input t_byte_q q, input bit empty_tail);
        int n;
        n = q.size();
        if (n == 0) send_word(8'($urandom), 1'b0, 1'b1);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0) send_word(8'($urandom), 1'b0, 1'b0);
            send_word(q[i], 1'b1, (i == n - 1) && !empty_tail);
        end
        if (n > 0 && empty_tail) send_word(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_detect(input logic v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_byte_q text_bytes(string s);
        t_byte_q q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    function automatic t_byte_q sign_part();
        t_byte_q q;
        int r;
        r = $urandom_range(0, 2);
        if (r == 1) q.push_back(ilp_pkg::CH_MINUS);
        else if (r == 2) q.push_back(ilp_pkg::CH_PLUS);
        return q;
    endfunction

    function automatic t_byte_q digit_run(int base, int count);
        t_byte_q q;
        int v;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 7) == 0) q.push_back(ilp_pkg::CH_UNDERSCORE);
            v = $urandom_range(0, base - 1);
            if (v < 10) q.push_back(ilp_pkg::CH_ZERO + 8'(v));
            else q.push_back((ilp_pkg::CH_UPPER_A + 8'(v - 10)) |
                             ($urandom_range(0, 1) ? ilp_pkg::LOWER_BIT : 8'h00));
        end
        return q;
    endfunction

    function automatic t_byte_q number_token(bit prefixed);
        t_byte_q    q;
        logic [7:0] letters[3];
        int         bases[3];
        int         sel;
        int         base;
        int         count;
        bit         longrun;
        letters = '{ilp_pkg::CH_LOWER_B, ilp_pkg::CH_LOWER_O, ilp_pkg::CH_LOWER_X};
        bases   = '{2, 8, 16};
        q       = sign_part();
        longrun = ($urandom_range(0, 9) == 0);
        if (prefixed) begin
            sel  = $urandom_range(0, 2);
            base = bases[sel];
            q.push_back(ilp_pkg::CH_ZERO);
            q.push_back($urandom_range(0, 1) ? (letters[sel] & ilp_pkg::CASE_MASK)
                                              : letters[sel]);
            if (!longrun) count = $urandom_range(0, 6);
            else if (base == 2) count = $urandom_range(60, 70);
            else if (base == 8) count = $urandom_range(20, 25);
            else count = $urandom_range(14, 18);
        end else begin
            base  = 10;
            count = longrun ? $urandom_range(15, 22) : $urandom_range(1, 6);
        end
        q = {q, digit_run(base, count)};
        return q;
    endfunction

    function automatic t_byte_q make_token();
        t_byte_q q;
        string   odd_chars;
        int      kind;
        int      pos;
        int      k;
        odd_chars = "+-0_xXbBoO9aAzZ@`[{/:";
        kind      = $urandom_range(0, 99);
        if (kind < 25) begin
            q = number_token(1'b0);
        end else if (kind < 50) begin
            q = number_token(1'b1);
        end else if (kind < 65) begin
            k = $urandom_range(0, 2);
            if (k == ilp_pkg::KW_FALSE) q = text_bytes("false");
            else if (k == ilp_pkg::KW_NULL) q = text_bytes("null");
            else q = text_bytes("true");
            pos = $urandom_range(0, q.size() - 1);
            case ($urandom_range(0, 5))
                0: repeat ($urandom_range(1, q.size())) void'(q.pop_back());
                1: q.push_back(8'($urandom_range(8'h61, 8'h7A)));
                2: q[pos] = q[pos] ^ ilp_pkg::LOWER_BIT;
                3: q[pos] = 8'($urandom);
                default: ;
            endcase
        end else if (kind < 80) begin
            q   = number_token(1'($urandom_range(0, 1)));
            pos = $urandom_range(0, q.size());
            if (pos == q.size()) q.push_back(8'($urandom));
            else q[pos] = 8'($urandom);
        end else if (kind < 90) begin
            repeat ($urandom_range(1, 5)) begin
                if ($urandom_range(0, 1)) q.push_back(8'($urandom));
                else q.push_back(odd_chars[$urandom_range(0, odd_chars.len() - 1)]);
            end
        end else begin
            q = sign_part();
            case ($urandom_range(0, 3))
                0: ;
                1: q.push_back(ilp_pkg::CH_ZERO);
                2: begin
                    q.push_back(ilp_pkg::CH_ZERO);
                    q.push_back(8'($urandom));
                end
                default: begin
                    repeat ($urandom_range(1, 3)) q.push_back(ilp_pkg::CH_UNDERSCORE);
                    q = {q, digit_run(10, $urandom_range(0, 2))};
                end
            endcase
        end
        return q;
    endfunction

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_detect(1'b1);
        send_token(text_bytes(""), 1'b0);
        send_token(text_bytes("-"), 1'b0);
        send_token(text_bytes("0"), 1'b0);
        send_token(text_bytes("0x"), 1'b0);
        send_token(text_bytes("_"), 1'b0);
        send_token(text_bytes("0z"), 1'b0);
        send_token(text_bytes("true"), 1'b0);
        send_token(text_bytes("-9"), 1'b0);
        raw.delete();
        raw.push_back(8'hFF);
        send_token(raw, 1'b1);
        raw.delete();
        raw.push_back(8'h00);
        send_token(raw, 1'b0);
        send_token(text_bytes("0b1"), 1'b0);
        write_detect(1'b0);
        send_token(text_bytes("0x1"), 1'b0);
        send_token(text_bytes("_"), 1'b0);

        for (int p = 0; p < 4; p++) begin
            write_detect(1'(p + 1));
            word_count = 0;
            while (word_count < PHASE_WORDS) send_token(make_token(), $urandom_range(0, 7) == 0);
        end

        drain();
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("integer_literal_parser_unit test passed");
        end else begin
            $display("integer_literal_parser_unit test failed");
        end
        $finish;
    end
endmodule
